@@ design/signed_int_to_decimal_ascii_unit_macros.svh @@
// Assertion macros for the checker file of the decimal text unit.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// Concurrent assertion on a clock, disabled while the active-low reset is low.
`define SIDASC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, but also checked while reset is held.
`define SIDASC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/sidasc_pkg.sv @@
// Shared constants of the signed integer to decimal text unit.
`default_nettype none

package sidasc_pkg;

    localparam int CHAR_BITS = 6;
    localparam int OUT_BYTES_W = 8;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 6'd57;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;

endpackage

`default_nettype wire

@@ design/signed_int_to_decimal_ascii_unit.sv @@
// Sequence: the value is taken in idle and converted by a bit-serial double-dabble BCD
// shift loop; leading zeros are dropped until a nonzero or final digit shows; then one
// character per cycle goes out while the output is not stalled, the sign first when
// negative. No new value is taken until the previous one's last character is loaded.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
`default_nettype none

module signed_int_to_decimal_ascii_unit
    import sidasc_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // tdata: value [VALUE_BITS-1:0], zero padded to whole bytes
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // tdata: char_code [5:0], zeros [7:6]
    output logic [OUT_BYTES_W-1:0]                   o_m_axis_tdata,
    output logic                                     o_m_axis_tlast
);

    // digits of 2^(VALUE_BITS-1): floor((VALUE_BITS-1) * log10(2)) + 1
    localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    t_state                  r_state;
    logic [VALUE_BITS-1:0]   r_mag;
    logic [BCD_W-1:0]        r_bcd;
    logic                    r_neg;
    logic [BIT_CNT_W-1:0]    r_bit_cnt;
    logic [DIG_CNT_W-1:0]    r_dig_cnt;
    logic                    r_out_valid;
    logic [CHAR_BITS-1:0]    r_out_char;
    logic                    r_out_last;

    logic [VALUE_BITS-1:0]   w_raw;
    logic [VALUE_BITS-1:0]   w_mag;
    logic [BCD_W-1:0]        w_adj;
    logic [BCD_W-1:0]        n_bcd;
    logic [3:0]              w_top;
    logic                    w_slot;
    logic                    w_load;
    logic                    w_in_xfer;

    assign w_raw     = i_s_axis_tdata[VALUE_BITS-1:0];
    // most negative value wraps to itself, which reads as 2^(VALUE_BITS-1) unsigned
    assign w_mag     = w_raw[VALUE_BITS-1] ? (~w_raw + VALUE_BITS'(1)) : w_raw;
    assign w_top     = r_bcd[BCD_W-1 -: 4];
    assign w_slot    = !r_out_valid || i_m_axis_tready;
    // a character goes into the output register this cycle
    assign w_load    = w_slot && (r_state == ST_SIGN || r_state == ST_EMIT);
    assign w_in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // add-3 correction on every digit, then shift in the next magnitude bit
    always_comb begin
        for (int g = 0; g < NUM_DIGITS; g++) begin
            if (r_bcd[g*4 +: 4] >= 4'd5) begin
                w_adj[g*4 +: 4] = r_bcd[g*4 +: 4] + 4'd3;
            end else begin
                w_adj[g*4 +: 4] = r_bcd[g*4 +: 4];
            end
        end
        n_bcd = {w_adj[BCD_W-2:0], r_mag[VALUE_BITS-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_mag     <= w_mag;
                        r_neg     <= w_raw[VALUE_BITS-1];
                        r_bcd     <= '0;
                        r_bit_cnt <= BIT_CNT_W'(VALUE_BITS);
                        r_state   <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    r_bcd     <= n_bcd;
                    r_mag     <= {r_mag[VALUE_BITS-2:0], 1'b0};
                    r_bit_cnt <= r_bit_cnt - BIT_CNT_W'(1);
                    if (r_bit_cnt == BIT_CNT_W'(1)) begin
                        r_dig_cnt <= DIG_CNT_W'(NUM_DIGITS);
                        r_state   <= ST_SKIP;
                    end
                end
                ST_SKIP: begin
                    // keep at least one digit so zero prints as '0'
                    if (w_top == 4'd0 && r_dig_cnt != DIG_CNT_W'(1)) begin
                        r_bcd     <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_dig_cnt <= r_dig_cnt - DIG_CNT_W'(1);
                    end else if (r_neg) begin
                        r_state <= ST_SIGN;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_SIGN: begin
                    if (w_slot) begin
                        r_out_char  <= CHAR_MINUS;
                        r_out_last  <= 1'b0;
                        r_state     <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_slot) begin
                        r_out_char  <= CHAR_ZERO + {2'b00, w_top};
                        r_out_last  <= (r_dig_cnt == DIG_CNT_W'(1));
                        r_bcd       <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_dig_cnt   <= r_dig_cnt - DIG_CNT_W'(1);
                        if (r_dig_cnt == DIG_CNT_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_BYTES_W-CHAR_BITS){1'b0}}, r_out_char};
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

@@ design/sidasc_checker.sv @@
// Port-level checker for the decimal text unit, bound to the top level.
`default_nettype none
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module sidasc_checker
    import sidasc_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_tvalid,
    input wire logic                   i_s_tready,
    input wire logic                   i_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_BYTES_W-1:0] i_m_tdata,
    input wire logic                   i_m_tlast
);

    logic [CHAR_BITS-1:0] w_char;
    logic                 w_pad_zero;

    assign w_char     = i_m_tdata[CHAR_BITS-1:0];
    assign w_pad_zero = (i_m_tdata[OUT_BYTES_W-1:CHAR_BITS] == '0);

    // a stalled character holds
    `SIDASC_ASSERT(a_out_hold, i_clk, i_rst_n, (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast)), "output changed while stalled")

    `SIDASC_ASSERT(a_char_range, i_clk, i_rst_n, i_m_tvalid |-> (w_pad_zero && (w_char == CHAR_MINUS || (w_char >= CHAR_ZERO && w_char <= CHAR_NINE))), "character outside '-' and digits")

    // the sign always has digits after it
    `SIDASC_ASSERT(a_minus_not_last, i_clk, i_rst_n, (i_m_tvalid && w_char == CHAR_MINUS) |-> !i_m_tlast, "sign flagged as last")

    // one item at a time: input closes right after a transfer
    `SIDASC_ASSERT(a_one_item, i_clk, i_rst_n, (i_s_tvalid && i_s_tready) |=> !i_s_tready, "input ready after taking an item")

endmodule

bind signed_int_to_decimal_ascii_unit sidasc_checker u_sidasc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tlast  (o_m_axis_tlast)
);

`default_nettype wire

@@ test/tb_signed_int_to_decimal_ascii_unit.sv @@
`timescale 1ns / 1ps
// Testbench for the signed integer to decimal ASCII unit: directed and random values, random stalls, scoreboard check.

module tb_signed_int_to_decimal_ascii_unit;
    import sidasc_pkg::*;

    localparam int VALUE_BITS   = 32;
    localparam int NUM_DIRECTED = 20;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_AFTER   = 80;    // transfers accepted before the long output stall
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;  // cycles without any transfer before giving up
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [CHAR_BITS-1:0] code;
        logic                 last;
    } ascii_char_t;

    // Predicts the character run of each accepted value and checks the output stream.
    class decimal_text_scoreboard;
        ascii_char_t expected_chars[$];
        int          mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function void note_value(logic [VALUE_BITS-1:0] value);
            logic [VALUE_BITS:0] magnitude;
            logic [3:0]          digits[$];
            ascii_char_t         ch;
            logic                negative;
            negative  = value[VALUE_BITS-1];
            // one extra bit so the most negative value has room for its magnitude
            magnitude = negative ? ({1'b0, ~value} + 1'b1) : {1'b0, value};
            do begin
                digits.push_front(4'(magnitude % 10));
                magnitude = magnitude / 10;
            end while (magnitude != 0);
            if (negative) begin
                ch.code = CHAR_MINUS;
                ch.last = 1'b0;
                expected_chars.push_back(ch);
            end
            foreach (digits[k]) begin
                ch.code = CHAR_ZERO + CHAR_BITS'(digits[k]);
                ch.last = (k == digits.size() - 1);
                expected_chars.push_back(ch);
            end
        endfunction

        function void check_char(logic [CHAR_BITS-1:0] code, logic last);
            ascii_char_t want;
            if (expected_chars.size() == 0) begin
                $error("unexpected character transfer: char_code=%0d last=%0b", code, last);
                mismatch_count++;
                return;
            end
            want = expected_chars.pop_front();
            if (want.code !== code) begin
                $error("char_code mismatch: expected %0d, actual %0d", want.code, code);
                mismatch_count++;
            end
            if (want.last !== last) begin
                $error("last mismatch: expected %0b, actual %0b", want.last, last);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [VALUE_BITS-1:0] s_tdata  = '0;
    logic                  m_tready = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_BYTES_W-1:0] m_tdata;
    logic                  m_tlast;

    decimal_text_scoreboard scoreboard = new();
    int                     sent_count = 0;
    logic                   steady     = 1'b0;  // no idling on either side while set
    logic                   backpressure_done = 1'b0;
    int                     stall_cycles = 0;

    signed_int_to_decimal_ascii_unit #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Offer one value, with an occasional gap first, and wait for its transfer.
    task automatic send_value(input logic [VALUE_BITS-1:0] value);
        if (!steady && $urandom_range(0, 99) < 18) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        scoreboard.note_value(value);
        sent_count++;
    endtask

    // Mix of full-range, short, tiny and power-of-ten boundary values.
    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] v;
        logic [VALUE_BITS-1:0] p;
        p = 1;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom >> $urandom_range(0, 31);
            2: v = $urandom_range(0, 20);
            default: begin
                repeat ($urandom_range(0, 9)) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
            end
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    // Output side: random stalls, plus one long hold-off so the unit backs up.
    initial begin
        forever begin
            @(posedge i_clk);
            if (!backpressure_done && sent_count >= HOLD_AFTER) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                backpressure_done = 1'b1;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= 18);
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && m_tvalid && m_tready)
            scoreboard.check_char(m_tdata[CHAR_BITS-1:0], m_tlast);
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int directed_values [NUM_DIRECTED] = '{
            0, 1, -1, 9, -9, 10, -10, 99, -100, 12345,
            -67890, 999999999, 1000000000, -1000000000, 32'h7FFF_FFFF,
            32'h8000_0001, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 2147483646
        };
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_values[k]) send_value(directed_values[k]);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 200 && n < 320);
            send_value(random_value());
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scoreboard.mismatch_count == 0 && scoreboard.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
